### design/etm_pkg.sv
// Shared types, constants and arithmetic helpers for the TRS matrix builder.
package etm_pkg;

	localparam int NF = 26;
	localparam int NRED = 8;
	localparam int NCORDIC = 16;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	localparam logic [31:0] FULL_TURN = 32'd23592960;
	localparam logic signed [32:0] FULL_TURN_S = 33'sd23592960;
	localparam logic signed [32:0] HALF_TURN_S = 33'sd11796480;
	localparam logic signed [32:0] QUARTER_TURN_S = 33'sd5898240;
	localparam logic signed [32:0] BIAS_REM = 33'sd524288;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] ATAN_DEG [0:NCORDIC-1] = '{
		32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
		32'sd234379, 32'sd117304, 32'sd58666, 32'sd29335,
		32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
		32'sd917, 32'sd458, 32'sd229, 32'sd115
	};

	typedef logic signed [33:0] q30_t;
	typedef logic signed [31:0] q16_t;

	typedef struct packed {
		q16_t pos_x;
		q16_t pos_y;
		q16_t pos_z;
		q16_t pitch_deg;
		q16_t yaw_deg;
		q16_t roll_deg;
		q16_t scale_x;
		q16_t scale_y;
		q16_t scale_z;
	} in_t;

	typedef struct packed {
		q16_t c0_x;
		q16_t c0_y;
		q16_t c0_z;
		q16_t c1_x;
		q16_t c1_y;
		q16_t c1_z;
		q16_t c2_x;
		q16_t c2_y;
		q16_t c2_z;
		q16_t t_x;
		q16_t t_y;
		q16_t t_z;
	} out_t;

	typedef struct packed {
		logic [31:0] r;
		logic flip;
		q30_t x;
		q30_t y;
		q16_t z;
	} lane_t;

	typedef struct packed {
		lane_t [2:0] ln;
		q16_t [2:0] pos;
		q16_t [2:0] sc;
	} fst_t;

	typedef struct packed {
		q30_t cp, sp, cy, sy, cr, sr;
		q16_t [2:0] pos;
		q16_t [2:0] sc;
	} mid_t;

	typedef struct packed {
		q30_t cp, sp, cy, sy, cr, sr;
		q30_t crcy, spsy, spcy, cpsy, srcp, crcp, cpcy, cysr, crsy, srsy;
		q30_t a0, a1, a6, a7;
		q30_t [8:0] e;
		q16_t [2:0] pos;
		q16_t [2:0] sc;
	} bst_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic signed [67:0] p;
		begin
			p = a * b + 68'sd536870912;
			p = p >>> 30;
			return p[33:0];
		end
	endfunction

	function automatic q16_t scale_sat(input q30_t r, input q16_t s);
		logic signed [65:0] p;
		begin
			p = r * s + 66'sd536870912;
			p = p >>> 30;
			if (p > 66'sd2147483647) begin
				return 32'sh7fffffff;
			end else if (p < -66'sd2147483648) begin
				return 32'sh80000000;
			end
			return p[31:0];
		end
	endfunction

endpackage

### design/euler_trs_matrix_builder.sv
// Top level of the Euler-angle TRS model-matrix builder.
//   channel | direction | handshake        | payload
//   item    | in        | push / full      | in_t, position, angles, scale
//   result  | out       | pop / empty      | out_t, upper three matrix rows
// One request is taken per cycle while full is low. Each request passes through
// the 26-stage angle reduction and CORDIC pipeline and the 4-stage multiply
// and scale pipeline. Reset empties every stage and queue.
// When the result queue fills, the back part stalls, then the middle queue
// fills and the front part stalls and raises full.
module euler_trs_matrix_builder (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  etm_pkg::in_t item,
	output logic empty,
	input  logic pop,
	output etm_pkg::out_t result
);

	etm_pkg::qstat_t mid_stat;
	etm_pkg::mid_t mid_wdata, mid_rdata;
	logic mid_push, mid_pop;

	etm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .item(item), .full(full),
		.mid_stat(mid_stat), .mid_push(mid_push), .mid_data(mid_wdata)
	);

	etm_mid_q u_mid (
		.clk(clk), .arst_n(arst_n), .wr(mid_push), .wdata(mid_wdata),
		.rd(mid_pop), .rdata(mid_rdata), .stat(mid_stat)
	);

	etm_back u_back (
		.clk(clk), .arst_n(arst_n), .mid_stat(mid_stat), .mid_data(mid_rdata),
		.mid_pop(mid_pop), .empty(empty), .pop(pop), .result(result)
	);

endmodule

### design/etm_front.sv
// Front part: angle reduction and pipelined CORDIC sine and cosine.
module etm_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  etm_pkg::in_t item,
	output logic full,
	input  etm_pkg::qstat_t mid_stat,
	output logic mid_push,
	output etm_pkg::mid_t mid_data
);

	etm_pkg::fst_t st_s1 [0:etm_pkg::NF];
	logic v_s1 [0:etm_pkg::NF];
	logic en;

	function automatic etm_pkg::lane_t lstep(input int k, input etm_pkg::lane_t a);
		etm_pkg::lane_t o;
		logic [31:0] lim;
		logic signed [32:0] m;
		logic signed [33:0] dx, dy;
		int i;
		begin
			o = a;
			if (k < etm_pkg::NRED) begin
				lim = etm_pkg::FULL_TURN << (etm_pkg::NRED - 1 - k);
				if (a.r >= lim) begin
					o.r = a.r - lim;
				end
			end else if (k == etm_pkg::NRED) begin
				m = $signed({1'b0, a.r}) - etm_pkg::BIAS_REM;
				if (m < 0) begin
					m = m + etm_pkg::FULL_TURN_S;
				end
				if (m > etm_pkg::HALF_TURN_S) begin
					m = m - etm_pkg::FULL_TURN_S;
				end
				o.flip = 1'b0;
				if (m > etm_pkg::QUARTER_TURN_S) begin
					m = m - etm_pkg::HALF_TURN_S;
					o.flip = 1'b1;
				end else if (m < -etm_pkg::QUARTER_TURN_S) begin
					m = m + etm_pkg::HALF_TURN_S;
					o.flip = 1'b1;
				end
				o.z = m[31:0];
				o.x = etm_pkg::CORDIC_GAIN;
				o.y = '0;
			end else if (k < etm_pkg::NRED + 1 + etm_pkg::NCORDIC) begin
				i = k - etm_pkg::NRED - 1;
				dx = a.y >>> i;
				dy = a.x >>> i;
				if (a.z >= 0) begin
					o.x = a.x - dx;
					o.y = a.y + dy;
					o.z = a.z - etm_pkg::ATAN_DEG[i];
				end else begin
					o.x = a.x + dx;
					o.y = a.y - dy;
					o.z = a.z + etm_pkg::ATAN_DEG[i];
				end
			end else begin
				if (a.flip) begin
					o.x = -a.x;
					o.y = -a.y;
				end
			end
			return o;
		end
	endfunction

	assign en = !(v_s1[etm_pkg::NF] && mid_stat.full);
	assign full = !en;
	assign mid_push = v_s1[etm_pkg::NF] && !mid_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1[0] <= 1'b0;
		end else if (en) begin
			v_s1[0] <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1[0].pos <= {item.pos_z, item.pos_y, item.pos_x};
			st_s1[0].sc <= {item.scale_z, item.scale_y, item.scale_x};
			st_s1[0].ln[0] <= '{r: {~item.pitch_deg[31], item.pitch_deg[30:0]},
				flip: 1'b0, x: '0, y: '0, z: '0};
			st_s1[0].ln[1] <= '{r: {~item.yaw_deg[31], item.yaw_deg[30:0]},
				flip: 1'b0, x: '0, y: '0, z: '0};
			st_s1[0].ln[2] <= '{r: {~item.roll_deg[31], item.roll_deg[30:0]},
				flip: 1'b0, x: '0, y: '0, z: '0};
		end
	end

	for (genvar k = 0; k < etm_pkg::NF; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k+1] <= 1'b0;
			end else if (en) begin
				v_s1[k+1] <= v_s1[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s1[k+1].pos <= st_s1[k].pos;
				st_s1[k+1].sc <= st_s1[k].sc;
				for (int l = 0; l < 3; l++) begin
					st_s1[k+1].ln[l] <= lstep(k, st_s1[k].ln[l]);
				end
			end
		end
	end

	always_comb begin
		mid_data.cp = st_s1[etm_pkg::NF].ln[0].x;
		mid_data.sp = st_s1[etm_pkg::NF].ln[0].y;
		mid_data.cy = st_s1[etm_pkg::NF].ln[1].x;
		mid_data.sy = st_s1[etm_pkg::NF].ln[1].y;
		mid_data.cr = st_s1[etm_pkg::NF].ln[2].x;
		mid_data.sr = st_s1[etm_pkg::NF].ln[2].y;
		mid_data.pos = st_s1[etm_pkg::NF].pos;
		mid_data.sc = st_s1[etm_pkg::NF].sc;
	end

endmodule

### design/etm_mid_q.sv
// Short queue of sine and cosine sets, with position and scale, between the front and back parts.
module etm_mid_q (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  etm_pkg::mid_t wdata,
	input  logic rd,
	output etm_pkg::mid_t rdata,
	output etm_pkg::qstat_t stat
);

	etm_pkg::mid_t mem_q [0:etm_pkg::MID_DEPTH-1];
	logic [$clog2(etm_pkg::MID_DEPTH)-1:0] wp_q, rp_q;
	logic [$clog2(etm_pkg::MID_DEPTH):0] cnt_q;

	assign stat.full = (cnt_q == ($clog2(etm_pkg::MID_DEPTH)+1)'(etm_pkg::MID_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/etm_back.sv
// Back part: rotation products, axis scaling, saturation and result queue.
module etm_back (
	input  logic clk,
	input  logic arst_n,
	input  etm_pkg::qstat_t mid_stat,
	input  etm_pkg::mid_t mid_data,
	output logic mid_pop,
	output logic empty,
	input  logic pop,
	output etm_pkg::out_t result
);

	etm_pkg::bst_t b_s1, b_s2, b_s3;
	etm_pkg::bst_t b1_d, b2_d, b3_d;
	etm_pkg::out_t b_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic en, oq_full, oq_push;
	etm_pkg::out_t oq_q [0:etm_pkg::OUT_DEPTH-1];
	logic [$clog2(etm_pkg::OUT_DEPTH)-1:0] wp_q, rp_q;
	logic [$clog2(etm_pkg::OUT_DEPTH):0] cnt_q;
	logic oq_pop;

	assign oq_full = (cnt_q == ($clog2(etm_pkg::OUT_DEPTH)+1)'(etm_pkg::OUT_DEPTH));
	assign empty = (cnt_q == '0);
	assign en = !(v_s4 && oq_full);
	assign mid_pop = en && !mid_stat.empty;
	assign oq_push = v_s4 && !oq_full;
	assign oq_pop = pop && !empty;
	assign result = oq_q[rp_q];

	always_comb begin
		b1_d = '0;
		b1_d.cp = mid_data.cp;
		b1_d.sp = mid_data.sp;
		b1_d.cy = mid_data.cy;
		b1_d.sy = mid_data.sy;
		b1_d.cr = mid_data.cr;
		b1_d.sr = mid_data.sr;
		b1_d.pos = mid_data.pos;
		b1_d.sc = mid_data.sc;
		b1_d.crcy = etm_pkg::mul_q30(mid_data.cr, mid_data.cy);
		b1_d.spsy = etm_pkg::mul_q30(mid_data.sp, mid_data.sy);
		b1_d.spcy = etm_pkg::mul_q30(mid_data.sp, mid_data.cy);
		b1_d.cpsy = etm_pkg::mul_q30(mid_data.cp, mid_data.sy);
		b1_d.srcp = etm_pkg::mul_q30(mid_data.sr, mid_data.cp);
		b1_d.crcp = etm_pkg::mul_q30(mid_data.cr, mid_data.cp);
		b1_d.cpcy = etm_pkg::mul_q30(mid_data.cp, mid_data.cy);
		b1_d.cysr = etm_pkg::mul_q30(mid_data.cy, mid_data.sr);
		b1_d.crsy = etm_pkg::mul_q30(mid_data.cr, mid_data.sy);
		b1_d.srsy = etm_pkg::mul_q30(mid_data.sr, mid_data.sy);
	end

	always_comb begin
		b2_d = b_s1;
		b2_d.a0 = etm_pkg::mul_q30(b_s1.sr, b_s1.spsy);
		b2_d.a1 = etm_pkg::mul_q30(b_s1.cr, b_s1.spsy);
		b2_d.a6 = etm_pkg::mul_q30(b_s1.sr, b_s1.spcy);
		b2_d.a7 = etm_pkg::mul_q30(b_s1.cr, b_s1.spcy);
	end

	always_comb begin
		b3_d = b_s2;
		b3_d.e[0] = b_s2.crcy + b_s2.a0;
		b3_d.e[1] = b_s2.cysr - b_s2.a1;
		b3_d.e[2] = -b_s2.cpsy;
		b3_d.e[3] = -b_s2.srcp;
		b3_d.e[4] = b_s2.crcp;
		b3_d.e[5] = -b_s2.sp;
		b3_d.e[6] = b_s2.crsy - b_s2.a6;
		b3_d.e[7] = b_s2.srsy + b_s2.a7;
		b3_d.e[8] = b_s2.cpcy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1 <= b1_d;
			b_s2 <= b2_d;
			b_s3 <= b3_d;

			b_s4.c0_x <= etm_pkg::scale_sat(b_s3.e[0], b_s3.sc[0]);
			b_s4.c0_y <= etm_pkg::scale_sat(b_s3.e[1], b_s3.sc[0]);
			b_s4.c0_z <= etm_pkg::scale_sat(b_s3.e[2], b_s3.sc[0]);
			b_s4.c1_x <= etm_pkg::scale_sat(b_s3.e[3], b_s3.sc[1]);
			b_s4.c1_y <= etm_pkg::scale_sat(b_s3.e[4], b_s3.sc[1]);
			b_s4.c1_z <= etm_pkg::scale_sat(b_s3.e[5], b_s3.sc[1]);
			b_s4.c2_x <= etm_pkg::scale_sat(b_s3.e[6], b_s3.sc[2]);
			b_s4.c2_y <= etm_pkg::scale_sat(b_s3.e[7], b_s3.sc[2]);
			b_s4.c2_z <= etm_pkg::scale_sat(b_s3.e[8], b_s3.sc[2]);
			b_s4.t_x <= b_s3.pos[0];
			b_s4.t_y <= b_s3.pos[1];
			b_s4.t_z <= b_s3.pos[2];
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[wp_q] <= b_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (oq_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (oq_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (oq_push && !oq_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (oq_pop && !oq_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/etm_checker.sv
// Port-level checks for the TRS matrix builder, bound to the top level.
module etm_checker (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input etm_pkg::out_t result
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("Result queue is not empty during reset.");

	a_reset_not_full: assert property (@(posedge clk) !arst_n |-> !full)
		else $error("Block reports full during reset.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("A waiting result changed or vanished before it was taken.");

endmodule

bind euler_trs_matrix_builder etm_checker u_etm_checker (
	.clk(clk), .arst_n(arst_n), .full(full),
	.empty(empty), .pop(pop), .result(result)
);
